// ===== hdl/fvc_pkg.sv =====
package fvc_pkg;

   localparam int INDEX_WIDTH = 32;
   localparam int COUNT_WIDTH = 32;
   localparam logic [COUNT_WIDTH-1:0] COUNT_MAX = {COUNT_WIDTH{1'b1}};

   // One cache slot as it moves down the row
   typedef struct packed {
      logic                   valid;
      logic [INDEX_WIDTH-1:0] index;
   } fvc_slot_type;

   // Per-cycle commands broadcast to every cell
   typedef struct packed {
      logic shift;
      logic flush;
   } fvc_ctrl_type;

   // Saturating increment for the mesh counters
   function automatic logic [COUNT_WIDTH-1:0] sat_inc(input logic [COUNT_WIDTH-1:0] value);
      logic [COUNT_WIDTH-1:0] result;
      result = (value == COUNT_MAX) ? value : value + {{(COUNT_WIDTH-1){1'b0}}, 1'b1};
      return result;
   endfunction

endpackage

// ===== hdl/fifo_vertex_cache_miss_counter.sv =====
// FIFO vertex cache miss counter: a row of CACHE_ENTRIES cells forms a fully
// associative cache with first-in-first-out replacement. Every accepted index
// is compared against all cells at once; a miss shifts the index into the head
// cell and the oldest entry drops off the tail. One word is accepted every
// cycle while the result register is free or being taken; the throughput is
// set by the combinational parallel compare and OR across the cell row. Each
// word gives one result with the running miss and index counts (saturating).
// A word with mesh_last set empties the cache and zeroes both counts after its
// result is formed. The cache starts empty after reset.
module fifo_vertex_cache_miss_counter #(
   parameter int CACHE_ENTRIES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  logic [fvc_pkg::INDEX_WIDTH-1:0] req_vertex_index,
   input  logic                            req_mesh_last,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output logic                            rsp_was_miss,
   output logic [fvc_pkg::COUNT_WIDTH-1:0] rsp_miss_total,
   output logic [fvc_pkg::COUNT_WIDTH-1:0] rsp_index_total,
   output logic                            rsp_is_last
);

   logic                            accept;
   logic                            hit;
   fvc_pkg::fvc_ctrl_type           ctrl;

   logic [fvc_pkg::COUNT_WIDTH-1:0] miss_ff, miss_in, miss_next;
   logic [fvc_pkg::COUNT_WIDTH-1:0] item_ff, item_in, item_next;
   logic                            rsp_valid_ff, rsp_valid_in;
   logic                            was_miss_ff;
   logic [fvc_pkg::COUNT_WIDTH-1:0] miss_total_ff;
   logic [fvc_pkg::COUNT_WIDTH-1:0] index_total_ff;
   logic                            is_last_ff;

   // Take a word whenever the result register is empty or draining
   assign req_stall = rsp_valid_ff && rsp_stall;
   assign accept    = req_valid && !req_stall;

   assign ctrl = '{shift: accept && !hit, flush: accept && req_mesh_last};

   fvc_chain #(
      .CACHE_ENTRIES (CACHE_ENTRIES)
   ) u_chain (
      .clock (clock),
      .reset (reset),
      .ctrl  (ctrl),
      .query (req_vertex_index),
      .hit   (hit)
   );

   // Advance the counters; clear them after the last word of a mesh
   always_comb begin
      miss_next = hit ? miss_ff : fvc_pkg::sat_inc(miss_ff);
      item_next = fvc_pkg::sat_inc(item_ff);
      miss_in   = miss_ff;
      item_in   = item_ff;
      if (accept) begin
         miss_in = req_mesh_last ? '0 : miss_next;
         item_in = req_mesh_last ? '0 : item_next;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         miss_ff <= '0;
         item_ff <= '0;
      end else begin
         miss_ff <= miss_in;
         item_ff <= item_in;
      end
   end

   // Hold the result until it is taken
   assign rsp_valid_in = accept || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         was_miss_ff    <= !hit;
         miss_total_ff  <= miss_next;
         index_total_ff <= item_next;
         is_last_ff     <= req_mesh_last;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_was_miss    = was_miss_ff;
   assign rsp_miss_total  = miss_total_ff;
   assign rsp_index_total = index_total_ff;
   assign rsp_is_last     = is_last_ff;

endmodule

// ===== hdl/fvc_cell.sv =====
module fvc_cell (
   input  logic                                clock,
   input  logic                                reset,
   input  fvc_pkg::fvc_ctrl_type               ctrl,
   input  logic [fvc_pkg::INDEX_WIDTH-1:0]     query,
   input  fvc_pkg::fvc_slot_type               prev_slot,
   output fvc_pkg::fvc_slot_type               slot,
   output logic                                match
);

   logic                            valid_ff;
   logic [fvc_pkg::INDEX_WIDTH-1:0] index_ff;

   // Drop the entry at end of mesh, else take the neighbor's entry on a miss
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ctrl.flush) begin
         valid_ff <= 1'b0;
      end else if (ctrl.shift) begin
         valid_ff <= prev_slot.valid;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.shift) begin
         index_ff <= prev_slot.index;
      end
   end

   // Compare the held index against the incoming one
   assign match = valid_ff && (index_ff == query);
   assign slot  = '{valid: valid_ff, index: index_ff};

endmodule

// ===== hdl/fvc_chain.sv =====
module fvc_chain #(
   parameter int CACHE_ENTRIES = 32
) (
   input  logic                            clock,
   input  logic                            reset,
   input  fvc_pkg::fvc_ctrl_type           ctrl,
   input  logic [fvc_pkg::INDEX_WIDTH-1:0] query,
   output logic                            hit
);

   fvc_pkg::fvc_slot_type        head;
   fvc_pkg::fvc_slot_type        link [CACHE_ENTRIES];
   logic [CACHE_ENTRIES-1:0]     match_vec;

   // New entries enter at cell zero; the oldest falls off the far end
   assign head = '{valid: 1'b1, index: query};

   for (genvar g = 0; g < CACHE_ENTRIES; g++) begin : g_cell
      if (g == 0) begin : g_first
         fvc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .query     (query),
            .prev_slot (head),
            .slot      (link[g]),
            .match     (match_vec[g])
         );
      end else begin : g_rest
         fvc_cell u_cell (
            .clock     (clock),
            .reset     (reset),
            .ctrl      (ctrl),
            .query     (query),
            .prev_slot (link[g-1]),
            .slot      (link[g]),
            .match     (match_vec[g])
         );
      end
   end

   assign hit = |match_vec;

endmodule

// ===== hdl/fvc_checker.sv =====
module fvc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input logic                            rsp_was_miss,
   input logic [fvc_pkg::COUNT_WIDTH-1:0] rsp_miss_total,
   input logic [fvc_pkg::COUNT_WIDTH-1:0] rsp_index_total,
   input logic                            rsp_is_last
);

   logic                            rsp_take;
   logic                            in_mesh_ff;
   logic [fvc_pkg::COUNT_WIDTH-1:0] prev_miss_ff;
   logic [fvc_pkg::COUNT_WIDTH-1:0] prev_index_ff;

   assign rsp_take = rsp_valid && !rsp_stall;

   // Track the last delivered word of the current mesh
   always_ff @(posedge clock) begin
      if (reset) begin
         in_mesh_ff <= 1'b0;
      end else if (rsp_take) begin
         in_mesh_ff <= !rsp_is_last;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_take) begin
         prev_miss_ff  <= rsp_miss_total;
         prev_index_ff <= rsp_index_total;
      end
   end

   // First word of a mesh always misses into an empty cache
   a_mesh_start: assert property (@(posedge clock) disable iff (reset)
      rsp_take && !in_mesh_ff |->
         rsp_was_miss && rsp_miss_total == 1 && rsp_index_total == 1)
      else $error("first word of mesh must miss with both counts at one");

   // Index count steps by one within a mesh
   a_index_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take && in_mesh_ff |-> rsp_index_total == fvc_pkg::sat_inc(prev_index_ff))
      else $error("index count did not advance by one");

   // Miss count follows the miss flag within a mesh
   a_miss_step: assert property (@(posedge clock) disable iff (reset)
      rsp_take && in_mesh_ff |->
         rsp_miss_total == (rsp_was_miss ? fvc_pkg::sat_inc(prev_miss_ff) : prev_miss_ff))
      else $error("miss count does not match miss flag");

   // A stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_miss_total)
         && $stable(rsp_index_total) && $stable(rsp_was_miss) && $stable(rsp_is_last))
      else $error("stalled result changed");

endmodule

bind fifo_vertex_cache_miss_counter fvc_checker u_fvc_checker (.*);

// ===== tb/tb_fifo_vertex_cache_miss_counter.sv =====
`timescale 1ns / 1ps

module tb_fifo_vertex_cache_miss_counter;

   localparam int SLOTS       = 32;
   localparam int CYCLE_LIMIT = 400000;
   localparam int DRAIN_WAIT  = 20;

   typedef struct packed {
      logic                            was_miss;
      logic [fvc_pkg::COUNT_WIDTH-1:0] miss_total;
      logic [fvc_pkg::COUNT_WIDTH-1:0] index_total;
      logic                            is_last;
   } lookup_result_type;

   logic                            clock            = 1'b0;
   logic                            reset            = 1'b1;
   logic                            req_valid        = 1'b0;
   logic                            req_stall;
   logic [fvc_pkg::INDEX_WIDTH-1:0] req_vertex_index = '0;
   logic                            req_mesh_last    = 1'b0;
   logic                            rsp_valid;
   logic                            rsp_stall        = 1'b0;
   logic                            rsp_was_miss;
   logic [fvc_pkg::COUNT_WIDTH-1:0] rsp_miss_total;
   logic [fvc_pkg::COUNT_WIDTH-1:0] rsp_index_total;
   logic                            rsp_is_last;

   // Cache image kept alongside the block
   logic [fvc_pkg::INDEX_WIDTH-1:0] cached_vertex [SLOTS];
   bit                              cached_live [SLOTS];
   int unsigned                     oldest_slot = 0;
   logic [fvc_pkg::COUNT_WIDTH-1:0] mesh_misses = '0;
   logic [fvc_pkg::COUNT_WIDTH-1:0] mesh_indices = '0;
   lookup_result_type               pending_lookups [$];

   int unsigned error_count   = 0;
   int unsigned cycle_count   = 0;
   int unsigned words_sent    = 0;
   int unsigned misses_seen   = 0;
   int unsigned meshes_closed = 0;
   int unsigned send_idle_pct = 0;
   int unsigned recv_idle_pct = 0;
   int unsigned stall_left    = 0;

   fifo_vertex_cache_miss_counter dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_vertex_index(req_vertex_index),
      .req_mesh_last   (req_mesh_last),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_was_miss    (rsp_was_miss),
      .rsp_miss_total  (rsp_miss_total),
      .rsp_index_total (rsp_index_total),
      .rsp_is_last     (rsp_is_last)
   );

   always #10 clock = ~clock;

   // Abort a hung run
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   // Stall the result channel in random bursts
   always @(posedge clock) begin
      if (reset) begin
         stall_left = 0;
         rsp_stall <= 1'b0;
      end else if (stall_left != 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if ($urandom_range(0, 99) < recv_idle_pct) begin
         stall_left = $urandom_range(1, 19) - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   // Compare each taken result word with the oldest prediction
   always @(posedge clock) begin
      lookup_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_lookups.size() == 0) begin
            $error("result word with no prediction pending");
            error_count++;
         end else begin
            want = pending_lookups.pop_front();
            if (rsp_was_miss !== want.was_miss) begin
               $error("was_miss: expected %0d, got %0d", want.was_miss, rsp_was_miss);
               error_count++;
            end
            if (rsp_miss_total !== want.miss_total) begin
               $error("miss_total: expected %0d, got %0d", want.miss_total, rsp_miss_total);
               error_count++;
            end
            if (rsp_index_total !== want.index_total) begin
               $error("index_total: expected %0d, got %0d",
                      want.index_total, rsp_index_total);
               error_count++;
            end
            if (rsp_is_last !== want.is_last) begin
               $error("is_last: expected %0d, got %0d", want.is_last, rsp_is_last);
               error_count++;
            end
            if (rsp_was_miss === 1'b1)
               misses_seen++;
         end
      end
   end

   // Look the index up in the cache image, update it, and queue the result
   function automatic void predict_lookup(input logic [fvc_pkg::INDEX_WIDTH-1:0] vertex,
                                          input logic last);
      lookup_result_type res;
      bit found;
      found = 1'b0;
      for (int n = 0; n < SLOTS; n++)
         if (cached_live[n] && cached_vertex[n] == vertex)
            found = 1'b1;
      if (!found) begin
         cached_vertex[oldest_slot] = vertex;
         cached_live[oldest_slot]   = 1'b1;
         oldest_slot = (oldest_slot + 1) % SLOTS;
         if (mesh_misses != fvc_pkg::COUNT_MAX)
            mesh_misses = mesh_misses + 1'b1;
      end
      if (mesh_indices != fvc_pkg::COUNT_MAX)
         mesh_indices = mesh_indices + 1'b1;
      res.was_miss    = !found;
      res.miss_total  = mesh_misses;
      res.index_total = mesh_indices;
      res.is_last     = last;
      pending_lookups.push_back(res);
      // End of mesh empties the cache and zeroes both counts
      if (last) begin
         for (int n = 0; n < SLOTS; n++)
            cached_live[n] = 1'b0;
         oldest_slot  = 0;
         mesh_misses  = '0;
         mesh_indices = '0;
         meshes_closed++;
      end
   endfunction

   // Present one word, with an optional idle burst first, and hold it until taken
   task automatic send_vertex(input logic [fvc_pkg::INDEX_WIDTH-1:0] vertex,
                              input logic last);
      if ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 19)) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_vertex_index <= vertex;
      req_mesh_last    <= last;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      predict_lookup(vertex, last);
      words_sent++;
   endtask

   // Drop valid and wait for every predicted result to come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_lookups.size() != 0) @(posedge clock);
   endtask

   // Extremes, hits, and the mesh-end clear
   task automatic test_directed();
      send_idle_pct = 0;
      recv_idle_pct = 0;
      send_vertex(32'h0000_0000, 1'b0);
      send_vertex(32'hFFFF_FFFF, 1'b0);
      send_vertex(32'h0000_0000, 1'b0);
      send_vertex(32'hFFFF_FFFF, 1'b0);
      send_vertex(32'hAAAA_AAAA, 1'b0);
      send_vertex(32'h5555_5555, 1'b0);
      send_vertex(32'h5555_5555, 1'b0);
      send_vertex(32'h0000_0000, 1'b1);
      // cache must be empty again after the mesh end
      send_vertex(32'h0000_0000, 1'b0);
      send_vertex(32'h0000_0000, 1'b1);
      send_vertex(32'hFFFF_FFFF, 1'b1);
      send_vertex(32'hFFFF_FFFF, 1'b0);
      send_vertex(32'h8000_0000, 1'b0);
      send_vertex(32'h0000_0001, 1'b0);
      send_vertex(32'h8000_0000, 1'b1);
      wait_drained();
   endtask

   // Fill every slot, then check that a hit does not refresh the oldest entry
   task automatic test_fifo_eviction();
      logic [fvc_pkg::INDEX_WIDTH-1:0] base;
      base = $urandom();
      send_idle_pct = 15;
      recv_idle_pct = 15;
      for (int n = 0; n < SLOTS; n++)
         send_vertex(base + n, 1'b0);
      send_vertex(base, 1'b0);
      send_vertex(base + SLOTS, 1'b0);
      send_vertex(base, 1'b0);
      send_vertex(base + SLOTS - 1, 1'b0);
      send_vertex(base + 1, 1'b1);
      wait_drained();
   endtask

   // Random meshes: index windows, strips, and plain noise
   task automatic test_random_meshes(input int unsigned word_target);
      logic [fvc_pkg::INDEX_WIDTH-1:0] base;
      logic [fvc_pkg::INDEX_WIDTH-1:0] vertex;
      int unsigned                     style;
      int unsigned                     mesh_len;
      int unsigned                     span;
      int unsigned                     stop_at;
      stop_at = words_sent + word_target;
      while (words_sent < stop_at) begin
         style    = $urandom_range(0, 9);
         mesh_len = $urandom_range(1, 120);
         span     = $urandom_range(1, 48);
         base     = $urandom();
         case ($urandom_range(0, 2))
            0: send_idle_pct = 0;
            1: send_idle_pct = 10;
            default: send_idle_pct = 40;
         endcase
         case ($urandom_range(0, 2))
            0: recv_idle_pct = 0;
            1: recv_idle_pct = 10;
            default: recv_idle_pct = 40;
         endcase
         for (int k = 0; k < mesh_len; k++) begin
            if (style < 5)
               vertex = base + $urandom_range(0, span - 1);
            else if (style < 8)
               vertex = base + k / 3 + k % 3;
            else
               vertex = $urandom();
            // a stray mesh end mid-stream now and then
            send_vertex(vertex, (k == mesh_len - 1) || ($urandom_range(0, 199) == 0));
         end
         if ($urandom_range(0, 5) == 0)
            wait_drained();
      end
      wait_drained();
   endtask

   // Full rate on both sides
   task automatic test_back_to_back(input int unsigned word_target);
      logic [fvc_pkg::INDEX_WIDTH-1:0] base;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      base = $urandom();
      for (int k = 0; k < word_target; k++)
         send_vertex(base + $urandom_range(0, 40), $urandom_range(0, 29) == 0);
      send_vertex(base, 1'b1);
      wait_drained();
   endtask

   initial begin
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_directed();
      test_fifo_eviction();
      test_random_meshes(950);
      test_back_to_back(100);
      repeat (DRAIN_WAIT) @(posedge clock);
      $display("Sent %0d index words over %0d meshes, %0d misses seen,",
               words_sent, meshes_closed, misses_seen);
      $display("with FIFO eviction, mesh-end clears, and random stalls on both sides.");
      if (error_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

// ===== fifo_vertex_cache_miss_counter.f =====
hdl/fvc_pkg.sv
hdl/fvc_cell.sv
hdl/fvc_chain.sv
hdl/fifo_vertex_cache_miss_counter.sv
hdl/fvc_checker.sv
tb/tb_fifo_vertex_cache_miss_counter.sv
